@@ rtl/hbm_pkg.sv @@
// ----------------------------------------------------------------------------
// hbm_pkg
// Shared types and constants of the heatmap box merge block: queue entry,
// box table entry, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package hbm_pkg;

   // default sizes handed to the top level
   localparam int MAX_BOXES_DEF = 10;
   localparam int GRID_SIZE_DEF = 64;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // field widths
   localparam int COORD_W = 6;
   localparam int SCORE_W = 8;
   localparam int SPAN_W  = 7;
   localparam int CSIZE_W = 7;
   localparam int POS_W   = 12;
   localparam int SIZE_W  = 13;
   localparam int CSR_W   = 8;

   // saturation limits of the pixel outputs
   localparam logic [POS_W-1:0]  POS_LIMIT  = 12'd4095;
   localparam logic [SIZE_W-1:0] SIZE_LIMIT = 13'd8191;

   // register reset values
   localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 8'sd0;
   localparam logic [CSIZE_W-1:0]        CELL_SIZE_RESET = 7'd8;

   // register indexes
   typedef enum logic [0:0] {
      REG_SCORE_THRESHOLD = 1'b0,
      REG_CELL_SIZE       = 1'b1
   } csr_reg_type;

   // one classified cell waiting for the back end
   typedef struct packed {
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic signed [SCORE_W-1:0] score;
      logic                      qual;
      logic                      frame_end;
   } cell_entry_type;

   // push side of the queue
   typedef struct packed {
      logic           push;
      cell_entry_type entry;
   } queue_push_type;

   // pop side of the queue
   typedef struct packed {
      logic           valid;
      cell_entry_type entry;
   } queue_head_type;

   // one stored box, in cells
   typedef struct packed {
      logic [COORD_W-1:0]        left;
      logic [COORD_W-1:0]        top;
      logic [SPAN_W-1:0]         wide;
      logic [SPAN_W-1:0]         tall;
      logic signed [SCORE_W-1:0] best;
   } box_entry_type;

   // back end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_APPEND,
      ST_EMIT_START,
      ST_EMIT,
      ST_EMPTY
   } back_state_type;

endpackage

@@ rtl/hbm_front.sv @@
// ----------------------------------------------------------------------------
// hbm_front
// Input side: takes cells, drops the ones that change nothing, and tags
// the rest with whether they qualify for merging before queueing them.
// ----------------------------------------------------------------------------
module hbm_front #(
   parameter int GRID_SIZE = hbm_pkg::GRID_SIZE_DEF
) (
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [hbm_pkg::COORD_W-1:0]                req_cell_x,
   input  logic [hbm_pkg::COORD_W-1:0]                req_cell_y,
   input  logic signed [hbm_pkg::SCORE_W-1:0]         req_cell_score,
   input  logic                                       req_frame_end,
   input  logic signed [hbm_pkg::SCORE_W-1:0]         score_threshold,
   input  logic                                       queue_full,
   output hbm_pkg::queue_push_type                    queue_push
);

   localparam int GRID_W = $clog2(GRID_SIZE + 1);
   localparam int CMP_W  = (GRID_W > hbm_pkg::COORD_W) ? GRID_W : hbm_pkg::COORD_W;

   logic on_grid;
   logic above;
   logic qual;

   // cell must lie on the grid and reach the threshold
   assign on_grid = (CMP_W'(req_cell_x) < CMP_W'(GRID_SIZE)) &&
                    (CMP_W'(req_cell_y) < CMP_W'(GRID_SIZE));
   assign above   = (req_cell_score >= score_threshold);
   assign qual    = on_grid && above;

   // a cell that neither qualifies nor ends a frame is absorbed here
   assign req_ready = !queue_full;

   always_comb begin
      queue_push.push            = req_valid && !queue_full && (qual || req_frame_end);
      queue_push.entry.x         = req_cell_x;
      queue_push.entry.y         = req_cell_y;
      queue_push.entry.score     = req_cell_score;
      queue_push.entry.qual      = qual;
      queue_push.entry.frame_end = req_frame_end;
   end

endmodule

@@ rtl/hbm_queue.sv @@
// ----------------------------------------------------------------------------
// hbm_queue
// Short first-in first-out queue of classified cells between the front
// and the back end.
// ----------------------------------------------------------------------------
module hbm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  hbm_pkg::queue_push_type queue_push,
   output logic                    queue_full,
   output hbm_pkg::queue_head_type queue_head,
   input  logic                    queue_pop
);

   hbm_pkg::cell_entry_type            slot_ff [hbm_pkg::QUEUE_DEPTH];
   logic [hbm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [hbm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [hbm_pkg::QUEUE_PTR_W:0]      fill_ff, fill_in;
   logic                               do_push;
   logic                               do_pop;

   assign queue_full       = (fill_ff == (hbm_pkg::QUEUE_PTR_W+1)'(hbm_pkg::QUEUE_DEPTH));
   assign queue_head.valid = (fill_ff != '0);
   assign queue_head.entry = slot_ff[rd_ptr_ff];

   assign do_push = queue_push.push && !queue_full;
   assign do_pop  = queue_pop && queue_head.valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= queue_push.entry;
      end
   end

   // front never pushes into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(queue_push.push && queue_full))
      else $error("queue push while full");

   // back never pops an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(queue_pop && !queue_head.valid))
      else $error("queue pop while empty");

endmodule

@@ rtl/hbm_back.sv @@
// ----------------------------------------------------------------------------
// hbm_back
// Back end: walks the box table for each qualifying queued cell, merges or appends,
// and at frame end streams every box out, scaled to pixels.
// ----------------------------------------------------------------------------
module hbm_back #(
   parameter int MAX_BOXES = hbm_pkg::MAX_BOXES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hbm_pkg::queue_head_type             queue_head,
   output logic                                queue_pop,
   input  logic [hbm_pkg::CSIZE_W-1:0]         cell_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hbm_pkg::POS_W-1:0]           rsp_box_x,
   output logic [hbm_pkg::POS_W-1:0]           rsp_box_y,
   output logic [hbm_pkg::SIZE_W-1:0]          rsp_box_width,
   output logic [hbm_pkg::SIZE_W-1:0]          rsp_box_height,
   output logic signed [hbm_pkg::SCORE_W-1:0]  rsp_box_peak,
   output logic                                rsp_box_valid,
   output logic                                rsp_box_overflow,
   output logic                                rsp_box_last
);

   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int SUM_W = hbm_pkg::SPAN_W + 1;
   localparam int PPOS_W  = hbm_pkg::COORD_W + hbm_pkg::CSIZE_W;
   localparam int PSIZE_W = hbm_pkg::SPAN_W + hbm_pkg::CSIZE_W;

   hbm_pkg::back_state_type   state_ff, state_in;
   hbm_pkg::cell_entry_type   cur_ff, cur_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;

   // box table
   hbm_pkg::box_entry_type    box_mem [MAX_BOXES];
   hbm_pkg::box_entry_type    rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   hbm_pkg::box_entry_type    wr_data;

   // merge datapath
   logic [SUM_W-1:0]          box_right, box_bottom, cell_right, cell_bottom;
   logic [SUM_W-1:0]          ext_right, ext_bottom;
   logic                      miss, hit;
   hbm_pkg::box_entry_type    merged;
   hbm_pkg::box_entry_type    fresh;

   // sequencing helpers
   logic                      last_idx;
   logic                      has_room;
   logic                      out_free;
   logic                      out_load;
   logic                      out_box;
   logic                      out_last_in;

   // scaled outputs
   logic [PPOS_W-1:0]         prod_x, prod_y;
   logic [PSIZE_W-1:0]        prod_w, prod_h;

   // output register
   logic                                 rsp_valid_ff;
   logic [hbm_pkg::POS_W-1:0]            box_x_ff, box_x_in;
   logic [hbm_pkg::POS_W-1:0]            box_y_ff, box_y_in;
   logic [hbm_pkg::SIZE_W-1:0]           box_w_ff, box_w_in;
   logic [hbm_pkg::SIZE_W-1:0]           box_h_ff, box_h_in;
   logic signed [hbm_pkg::SCORE_W-1:0]   peak_ff, peak_in;
   logic                                 bvalid_ff, bvalid_in;
   logic                                 ovf_ff, ovf_in;
   logic                                 last_ff;

   assign last_idx = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign has_room = (count_ff < CNT_W'(MAX_BOXES));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // overlap or touch test against the entry just read
   always_comb begin
      box_right   = SUM_W'(rd_data_ff.left) + SUM_W'(rd_data_ff.wide);
      box_bottom  = SUM_W'(rd_data_ff.top) + SUM_W'(rd_data_ff.tall);
      cell_right  = SUM_W'(cur_ff.x) + SUM_W'(1);
      cell_bottom = SUM_W'(cur_ff.y) + SUM_W'(1);
      miss = (box_right < SUM_W'(cur_ff.x)) || (box_bottom < SUM_W'(cur_ff.y)) ||
             (SUM_W'(rd_data_ff.left) > cell_right) ||
             (SUM_W'(rd_data_ff.top) > cell_bottom);
      hit  = !miss;
   end

   // union of box and cell, keeping the higher peak
   always_comb begin
      merged.left = (cur_ff.x < rd_data_ff.left) ? cur_ff.x : rd_data_ff.left;
      merged.top  = (cur_ff.y < rd_data_ff.top) ? cur_ff.y : rd_data_ff.top;
      ext_right   = (box_right > cell_right) ? box_right : cell_right;
      ext_bottom  = (box_bottom > cell_bottom) ? box_bottom : cell_bottom;
      merged.wide = hbm_pkg::SPAN_W'(ext_right - SUM_W'(merged.left));
      merged.tall = hbm_pkg::SPAN_W'(ext_bottom - SUM_W'(merged.top));
      merged.best = (cur_ff.score > rd_data_ff.best) ? cur_ff.score : rd_data_ff.best;
   end

   // new 1x1 box
   always_comb begin
      fresh.left = cur_ff.x;
      fresh.top  = cur_ff.y;
      fresh.wide = hbm_pkg::SPAN_W'(1);
      fresh.tall = hbm_pkg::SPAN_W'(1);
      fresh.best = cur_ff.score;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hbm_pkg::ST_IDLE: begin
            if (queue_head.valid) begin
               if (queue_head.entry.qual) begin
                  state_in = hbm_pkg::ST_START;
               end else if (queue_head.entry.frame_end) begin
                  state_in = hbm_pkg::ST_EMIT_START;
               end
            end
         end
         hbm_pkg::ST_START: begin
            state_in = (count_ff == '0) ? hbm_pkg::ST_APPEND : hbm_pkg::ST_SCAN;
         end
         hbm_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = cur_ff.frame_end ? hbm_pkg::ST_EMIT_START : hbm_pkg::ST_IDLE;
            end else if (last_idx) begin
               state_in = hbm_pkg::ST_APPEND;
            end
         end
         hbm_pkg::ST_APPEND: begin
            state_in = cur_ff.frame_end ? hbm_pkg::ST_EMIT_START : hbm_pkg::ST_IDLE;
         end
         hbm_pkg::ST_EMIT_START: begin
            state_in = (count_ff == '0) ? hbm_pkg::ST_EMPTY : hbm_pkg::ST_EMIT;
         end
         hbm_pkg::ST_EMIT: begin
            if (out_free && last_idx) begin
               state_in = hbm_pkg::ST_IDLE;
            end
         end
         hbm_pkg::ST_EMPTY: begin
            if (out_free) begin
               state_in = hbm_pkg::ST_IDLE;
            end
         end
         default: state_in = hbm_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      queue_pop   = 1'b0;
      cur_in      = cur_ff;
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      idx_in      = '0;
      rd_addr     = idx_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = merged;
      out_load    = 1'b0;
      out_box     = 1'b0;
      out_last_in = 1'b0;
      unique case (state_ff)
         hbm_pkg::ST_IDLE: begin
            queue_pop = queue_head.valid;
            cur_in    = queue_head.entry;
            rd_addr   = '0;
         end
         hbm_pkg::ST_START: begin
            rd_addr = '0;
         end
         hbm_pkg::ST_SCAN: begin
            if (hit) begin
               wr_en = 1'b1;
            end else if (!last_idx) begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end
         hbm_pkg::ST_APPEND: begin
            rd_addr = '0;
            if (has_room) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IDX_W-1:0];
               wr_data  = fresh;
               count_in = count_ff + 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
         end
         hbm_pkg::ST_EMIT_START: begin
            rd_addr = '0;
         end
         hbm_pkg::ST_EMIT: begin
            idx_in = idx_ff;
            if (out_free) begin
               out_load    = 1'b1;
               out_box     = 1'b1;
               out_last_in = last_idx;
               if (last_idx) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  idx_in     = '0;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         hbm_pkg::ST_EMPTY: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_last_in = 1'b1;
               dropped_in  = 1'b0;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hbm_pkg::ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // box table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         box_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= box_mem[rd_addr];
   end

   // scale cells to pixels with saturation
   always_comb begin
      prod_x = PPOS_W'(rd_data_ff.left) * PPOS_W'(cell_size);
      prod_y = PPOS_W'(rd_data_ff.top) * PPOS_W'(cell_size);
      prod_w = PSIZE_W'(rd_data_ff.wide) * PSIZE_W'(cell_size);
      prod_h = PSIZE_W'(rd_data_ff.tall) * PSIZE_W'(cell_size);
      box_x_in  = (prod_x > PPOS_W'(hbm_pkg::POS_LIMIT)) ? hbm_pkg::POS_LIMIT :
                  hbm_pkg::POS_W'(prod_x);
      box_y_in  = (prod_y > PPOS_W'(hbm_pkg::POS_LIMIT)) ? hbm_pkg::POS_LIMIT :
                  hbm_pkg::POS_W'(prod_y);
      box_w_in  = (prod_w > PSIZE_W'(hbm_pkg::SIZE_LIMIT)) ? hbm_pkg::SIZE_LIMIT :
                  hbm_pkg::SIZE_W'(prod_w);
      box_h_in  = (prod_h > PSIZE_W'(hbm_pkg::SIZE_LIMIT)) ? hbm_pkg::SIZE_LIMIT :
                  hbm_pkg::SIZE_W'(prod_h);
      peak_in   = rd_data_ff.best;
      bvalid_in = 1'b1;
      ovf_in    = dropped_ff;
      if (!out_box) begin
         box_x_in  = '0;
         box_y_in  = '0;
         box_w_in  = '0;
         box_h_in  = '0;
         peak_in   = '0;
         bvalid_in = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         box_x_ff  <= box_x_in;
         box_y_ff  <= box_y_in;
         box_w_ff  <= box_w_in;
         box_h_ff  <= box_h_in;
         peak_ff   <= peak_in;
         bvalid_ff <= bvalid_in;
         ovf_ff    <= ovf_in;
         last_ff   <= out_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_box_x        = box_x_ff;
   assign rsp_box_y        = box_y_ff;
   assign rsp_box_width    = box_w_ff;
   assign rsp_box_height   = box_h_ff;
   assign rsp_box_peak     = peak_ff;
   assign rsp_box_valid    = bvalid_ff;
   assign rsp_box_overflow = ovf_ff;
   assign rsp_box_last     = last_ff;

   // table never holds more boxes than it has room for
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BOXES))
      else $error("box count above table size");

   // scan only visits stored boxes
   a_scan_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hbm_pkg::ST_SCAN) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("scan index past stored boxes");

   // the last item of a frame empties the table and the overflow flag
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_last_in) |=> (count_ff == '0) && !dropped_ff)
      else $error("table not cleared after frame");

endmodule

@@ rtl/heatmap_box_merge.sv @@
// ----------------------------------------------------------------------------
// heatmap_box_merge
// Merges qualifying heatmap cells into bounding boxes and emits the boxes,
// scaled to pixels, at the end of each frame.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   cell_x, cell_y, cell_score, frame_end
//   rsp      out        rsp_valid/rsp_ready   box_x/y/width/height, peak, flags
//   csr      in         csr_we                csr_index, csr_wdata
//
// A qualifying cell passes through the back end as dequeue, first table read,
// a scan step per stored box up to the first hit, and the append if none hit.
// Cells that neither qualify nor end a frame are absorbed by the front end. A
// frame end streams the boxes, one box per cycle while rsp_ready is high (an
// empty frame gives one item with rsp_box_valid low); a four-entry queue lets
// the front run ahead. Reset is synchronous; the box table needs no clearing pass.
// ----------------------------------------------------------------------------
module heatmap_box_merge #(
   parameter int MAX_BOXES = hbm_pkg::MAX_BOXES_DEF,
   parameter int GRID_SIZE = hbm_pkg::GRID_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [hbm_pkg::COORD_W-1:0]         req_cell_x,
   input  logic [hbm_pkg::COORD_W-1:0]         req_cell_y,
   input  logic signed [hbm_pkg::SCORE_W-1:0]  req_cell_score,
   input  logic                                req_frame_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hbm_pkg::POS_W-1:0]           rsp_box_x,
   output logic [hbm_pkg::POS_W-1:0]           rsp_box_y,
   output logic [hbm_pkg::SIZE_W-1:0]          rsp_box_width,
   output logic [hbm_pkg::SIZE_W-1:0]          rsp_box_height,
   output logic signed [hbm_pkg::SCORE_W-1:0]  rsp_box_peak,
   output logic                                rsp_box_valid,
   output logic                                rsp_box_overflow,
   output logic                                rsp_box_last,
   input  logic                                csr_we,
   input  logic [0:0]                          csr_index,
   input  logic [hbm_pkg::CSR_W-1:0]           csr_wdata
);

   logic signed [hbm_pkg::SCORE_W-1:0]  threshold_ff, threshold_in;
   logic [hbm_pkg::CSIZE_W-1:0]         cell_size_ff, cell_size_in;
   hbm_pkg::queue_push_type             queue_push;
   hbm_pkg::queue_head_type             queue_head;
   logic                                queue_full;
   logic                                queue_pop;

   // register writes
   always_comb begin
      threshold_in = threshold_ff;
      cell_size_in = cell_size_ff;
      if (csr_we) begin
         unique case (hbm_pkg::csr_reg_type'(csr_index))
            hbm_pkg::REG_SCORE_THRESHOLD: threshold_in = csr_wdata;
            hbm_pkg::REG_CELL_SIZE:       cell_size_in = csr_wdata[hbm_pkg::CSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= hbm_pkg::THRESHOLD_RESET;
         cell_size_ff <= hbm_pkg::CELL_SIZE_RESET;
      end else begin
         threshold_ff <= threshold_in;
         cell_size_ff <= cell_size_in;
      end
   end

   // classify incoming cells
   hbm_front #(
      .GRID_SIZE(GRID_SIZE)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_cell_score  (req_cell_score),
      .req_frame_end   (req_frame_end),
      .score_threshold (threshold_ff),
      .queue_full      (queue_full),
      .queue_push      (queue_push)
   );

   // decoupling queue
   hbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_push (queue_push),
      .queue_full (queue_full),
      .queue_head (queue_head),
      .queue_pop  (queue_pop)
   );

   // merge and emit
   hbm_back #(
      .MAX_BOXES(MAX_BOXES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_head       (queue_head),
      .queue_pop        (queue_pop),
      .cell_size        (cell_size_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_box_x        (rsp_box_x),
      .rsp_box_y        (rsp_box_y),
      .rsp_box_width    (rsp_box_width),
      .rsp_box_height   (rsp_box_height),
      .rsp_box_peak     (rsp_box_peak),
      .rsp_box_valid    (rsp_box_valid),
      .rsp_box_overflow (rsp_box_overflow),
      .rsp_box_last     (rsp_box_last)
   );

endmodule
